>>> sv/gdsu_pkg.sv
// gdsu_pkg: shared types, constants and calendar helper functions
// for the gregorian date step unit; no dependencies
package gdsu_pkg;

  localparam int CMD_W   = 3;
  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int DOY_W   = 9;
  localparam int WD_W    = 3;
  localparam int QUO_W   = 8;
  localparam int REM_W   = 7;
  localparam int WSUM_W  = 14;

  localparam logic [YEAR_W-1:0]  YEAR_MAX  = 14'd9999;
  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  localparam logic [CMD_W-1:0] CMD_QUERY      = 3'd0;
  localparam logic [CMD_W-1:0] CMD_NEXT_DAY   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_PREV_DAY   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_NEXT_MONTH = 3'd3;
  localparam logic [CMD_W-1:0] CMD_PREV_MONTH = 3'd4;

  typedef struct packed {
    logic               valid;
    logic               err;
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
  } date_t;

  typedef struct packed {
    logic               valid;
    logic               err;
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [DAY_W-1:0]   dim;
    logic [DOY_W-1:0]   doy;
    logic               leap;
    logic [WSUM_W-1:0]  wsum;
  } facts_t;

  // floor(v / 100) by reciprocal, exact for every 14-bit value
  function automatic logic [QUO_W-1:0] div100(input logic [YEAR_W-1:0] v);
    logic [26:0] p;
    p = 27'(v) * 27'd5243;
    return p[26:19];
  endfunction

  function automatic logic [REM_W-1:0] rem100(input logic [YEAR_W-1:0] v,
                                              input logic [QUO_W-1:0] q);
    logic [YEAR_W-1:0] t;
    t = v - YEAR_W'(q) * 14'd100;
    return t[REM_W-1:0];
  endfunction

  function automatic logic leap_of(input logic [1:0] y_lo, input logic cent,
                                   input logic [1:0] q_lo);
    return ((y_lo == 2'd0) && !cent) || (cent && (q_lo == 2'd0));
  endfunction

  function automatic logic [DAY_W-1:0] mon_len(input logic [MONTH_W-1:0] m,
                                               input logic leap);
    logic [DAY_W-1:0] n;
    case (m) inside
      4'd2:                    n = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: n = 5'd30;
      default:                 n = 5'd31;
    endcase
    return n;
  endfunction

  function automatic logic [DOY_W-1:0] days_before(input logic [MONTH_W-1:0] m);
    logic [DOY_W-1:0] n;
    case (m)
      4'd1:    n = 9'd0;
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

  // floor(31 * mm / 12) for the march-based month index
  function automatic logic [DAY_W-1:0] month_offset(input logic [MONTH_W-1:0] mm);
    logic [DAY_W-1:0] n;
    case (mm)
      4'd1:    n = 5'd2;
      4'd2:    n = 5'd5;
      4'd3:    n = 5'd7;
      4'd4:    n = 5'd10;
      4'd5:    n = 5'd12;
      4'd6:    n = 5'd15;
      4'd7:    n = 5'd18;
      4'd8:    n = 5'd20;
      4'd9:    n = 5'd23;
      4'd10:   n = 5'd25;
      4'd11:   n = 5'd28;
      4'd12:   n = 5'd31;
      default: n = 5'd0;
    endcase
    return n;
  endfunction

  // residue mod 7 by folding octal digits, since 8 = 1 mod 7
  function automatic logic [WD_W-1:0] mod7(input logic [WSUM_W-1:0] s);
    logic [5:0] f1;
    logic [3:0] f2;
    logic [3:0] f3;
    f1 = 6'(s[2:0]) + 6'(s[5:3]) + 6'(s[8:6]) + 6'(s[11:9]) + 6'(s[13:12]);
    f2 = 4'(f1[2:0]) + 4'(f1[5:3]);
    f3 = 4'(f2[2:0]) + 4'(f2[3]);
    return (f3 >= 4'd7) ? 3'(f3 - 4'd7) : f3[2:0];
  endfunction

endpackage

>>> sv/gdsu_step.sv
// gdsu_step: input register, date validation and the day or month step
// depends on gdsu_pkg
module gdsu_step (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  logic [gdsu_pkg::CMD_W-1:0]   cmd,
  input  logic [gdsu_pkg::YEAR_W-1:0]  in_year,
  input  logic [gdsu_pkg::MONTH_W-1:0] in_month,
  input  logic [gdsu_pkg::DAY_W-1:0]   in_day,
  output gdsu_pkg::date_t              step_out
);
  import gdsu_pkg::*;

  logic               in_valid;
  logic [CMD_W-1:0]   in_cmd;
  logic [YEAR_W-1:0]  y0;
  logic [MONTH_W-1:0] m0;
  logic [DAY_W-1:0]   d0;

  logic [QUO_W-1:0]   q;
  logic [REM_W-1:0]   r;
  logic               leap;
  logic [DAY_W-1:0]   dim;
  logic [DAY_W-1:0]   prev_dim;
  logic               ok;
  date_t              step_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= accept;
    end
    if (accept) begin
      in_cmd <= cmd;
      y0     <= in_year;
      m0     <= in_month;
      d0     <= in_day;
    end
  end

  always_comb begin
    q        = div100(y0);
    r        = rem100(y0, q);
    leap     = leap_of(y0[1:0], r == '0, q[1:0]);
    dim      = mon_len(m0, leap);
    prev_dim = mon_len(m0 - 4'd1, leap);
    ok = (y0 != '0) && (y0 <= YEAR_MAX) && (m0 != '0) && (m0 <= MONTH_DEC) &&
         (d0 != '0) && (d0 <= dim);

    step_next.valid = in_valid;
    step_next.year  = y0;
    step_next.month = m0;
    step_next.day   = d0;
    unique case (in_cmd)
      CMD_NEXT_DAY: begin
        if (d0 == dim) begin
          step_next.day = 5'd1;
          if (m0 == MONTH_DEC) begin
            step_next.month = MONTH_JAN;
            step_next.year  = y0 + 14'd1;
          end else begin
            step_next.month = m0 + 4'd1;
          end
        end else begin
          step_next.day = d0 + 5'd1;
        end
      end
      CMD_PREV_DAY: begin
        if (d0 == 5'd1) begin
          if (m0 == MONTH_JAN) begin
            step_next.month = MONTH_DEC;
            step_next.year  = y0 - 14'd1;
            step_next.day   = 5'd31;
          end else begin
            step_next.month = m0 - 4'd1;
            step_next.day   = prev_dim;
          end
        end else begin
          step_next.day = d0 - 5'd1;
        end
      end
      CMD_NEXT_MONTH: begin
        if (m0 == MONTH_DEC) begin
          step_next.month = MONTH_JAN;
          step_next.year  = y0 + 14'd1;
        end else begin
          step_next.month = m0 + 4'd1;
        end
      end
      CMD_PREV_MONTH: begin
        if (m0 == MONTH_JAN) begin
          step_next.month = MONTH_DEC;
          step_next.year  = y0 - 14'd1;
        end else begin
          step_next.month = m0 - 4'd1;
        end
      end
      default: begin
      end
    endcase
    step_next.err = !ok || (step_next.year == '0) || (step_next.year > YEAR_MAX);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_out.valid <= 1'b0;
    end else begin
      step_out.valid <= step_next.valid;
    end
    step_out.err   <= step_next.err;
    step_out.year  <= step_next.year;
    step_out.month <= step_next.month;
    step_out.day   <= step_next.day;
  end

endmodule

>>> sv/gdsu_facts.sv
// gdsu_facts: century split of the shifted year, then leap year, month
// length, day clamp, day of year and weekday sum; depends on gdsu_pkg
module gdsu_facts (
  input  logic            clk,
  input  logic            rst,
  input  gdsu_pkg::date_t step_in,
  output gdsu_pkg::facts_t facts_out
);
  import gdsu_pkg::*;

  // century split stage
  logic               a_next;
  logic [YEAR_W-1:0]  yy_next;
  logic [MONTH_W-1:0] mm_next;
  logic [QUO_W-1:0]   q_next;
  logic [REM_W-1:0]   r_next;

  logic               div_valid;
  logic               div_err;
  logic [YEAR_W-1:0]  year;
  logic [MONTH_W-1:0] month;
  logic [DAY_W-1:0]   day;
  logic               a;
  logic [YEAR_W-1:0]  yy;
  logic [MONTH_W-1:0] mm;
  logic [QUO_W-1:0]   q;
  logic [REM_W-1:0]   r;

  // facts stage
  logic               cent;
  logic [QUO_W-1:0]   q_year;
  logic               leap;
  logic [DAY_W-1:0]   dim;
  logic [DAY_W-1:0]   dc;
  facts_t             facts_next;

  always_comb begin
    a_next  = (step_in.month <= MONTH_FEB);
    yy_next = step_in.year - YEAR_W'(a_next);
    mm_next = a_next ? step_in.month + 4'd10 : step_in.month - 4'd2;
    q_next  = div100(yy_next);
    r_next  = rem100(yy_next, q_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_valid <= 1'b0;
    end else begin
      div_valid <= step_in.valid;
    end
    div_err <= step_in.err;
    year    <= step_in.year;
    month   <= step_in.month;
    day     <= step_in.day;
    a       <= a_next;
    yy      <= yy_next;
    mm      <= mm_next;
    q       <= q_next;
    r       <= r_next;
  end

  always_comb begin
    cent   = a ? (r == 7'd99) : (r == '0);
    q_year = (a && (r == 7'd99)) ? q + 8'd1 : q;
    leap   = leap_of(year[1:0], cent, q_year[1:0]);
    dim    = mon_len(month, leap);
    dc     = (day > dim) ? dim : day;

    facts_next.valid = div_valid;
    facts_next.err   = div_err;
    facts_next.year  = year;
    facts_next.month = month;
    facts_next.day   = dc;
    facts_next.dim   = dim;
    facts_next.leap  = leap;
    facts_next.doy   = days_before(month) + DOY_W'(dc) +
                       DOY_W'(leap && (month > MONTH_FEB));
    facts_next.wsum  = WSUM_W'(dc) + yy + (yy >> 2) - WSUM_W'(q) +
                       WSUM_W'(q >> 2) + WSUM_W'(month_offset(mm));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      facts_out.valid <= 1'b0;
    end else begin
      facts_out.valid <= facts_next.valid;
    end
    facts_out.err   <= facts_next.err;
    facts_out.year  <= facts_next.year;
    facts_out.month <= facts_next.month;
    facts_out.day   <= facts_next.day;
    facts_out.dim   <= facts_next.dim;
    facts_out.doy   <= facts_next.doy;
    facts_out.leap  <= facts_next.leap;
    facts_out.wsum  <= facts_next.wsum;
  end

endmodule

>>> sv/gdsu_result.sv
// gdsu_result: weekday residue, remaining-day counts, error zeroing and
// the result register; depends on gdsu_pkg
module gdsu_result (
  input  logic                         clk,
  input  logic                         rst,
  input  gdsu_pkg::facts_t             facts_in,
  output logic                         done,
  output logic [gdsu_pkg::YEAR_W-1:0]  out_year,
  output logic [gdsu_pkg::MONTH_W-1:0] out_month,
  output logic [gdsu_pkg::DAY_W-1:0]   out_day,
  output logic [gdsu_pkg::WD_W-1:0]    weekday,
  output logic [gdsu_pkg::DOY_W-1:0]   day_of_year,
  output logic [gdsu_pkg::DAY_W-1:0]   left_in_month,
  output logic [gdsu_pkg::DOY_W-1:0]   left_in_year,
  output logic                         leap_flag,
  output logic                         weekend_flag,
  output logic                         error_flag
);
  import gdsu_pkg::*;

  logic [WD_W-1:0] wd;
  logic            ok;

  always_comb begin
    wd = mod7(facts_in.wsum);
    ok = !facts_in.err;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= facts_in.valid;
    end
    out_year      <= ok ? facts_in.year : '0;
    out_month     <= ok ? facts_in.month : '0;
    out_day       <= ok ? facts_in.day : '0;
    weekday       <= ok ? wd : '0;
    day_of_year   <= ok ? facts_in.doy : '0;
    left_in_month <= ok ? facts_in.dim - facts_in.day : '0;
    left_in_year  <= ok ? 9'd365 + DOY_W'(facts_in.leap) - facts_in.doy : '0;
    leap_flag     <= ok && facts_in.leap;
    weekend_flag  <= ok && ((wd == 3'd5) || (wd == 3'd6));
    error_flag    <= !ok;
  end

endmodule

>>> sv/gregorian_date_step_unit_core.sv
// gregorian_date_step_unit_core: top level of the gregorian date step unit
// pipeline: an accepted command passes the input register, step, century split,
// facts and result register before done is raised
// throughput: one transaction per cycle, busy is high only during reset
// reset: synchronous active-high rst clears all stage valid bits
// depends on gdsu_pkg, gdsu_step, gdsu_facts, gdsu_result
module gregorian_date_step_unit_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [gdsu_pkg::CMD_W-1:0]   cmd,
  input  logic [gdsu_pkg::YEAR_W-1:0]  in_year,
  input  logic [gdsu_pkg::MONTH_W-1:0] in_month,
  input  logic [gdsu_pkg::DAY_W-1:0]   in_day,
  output logic                         done,
  output logic [gdsu_pkg::YEAR_W-1:0]  out_year,
  output logic [gdsu_pkg::MONTH_W-1:0] out_month,
  output logic [gdsu_pkg::DAY_W-1:0]   out_day,
  output logic [gdsu_pkg::WD_W-1:0]    weekday,
  output logic [gdsu_pkg::DOY_W-1:0]   day_of_year,
  output logic [gdsu_pkg::DAY_W-1:0]   left_in_month,
  output logic [gdsu_pkg::DOY_W-1:0]   left_in_year,
  output logic                         leap_flag,
  output logic                         weekend_flag,
  output logic                         error_flag
);
  import gdsu_pkg::*;

  logic   accept;
  date_t  step_q;
  facts_t facts_q;

  assign busy   = rst;
  assign accept = start && !busy;

  gdsu_step u_step (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .cmd      (cmd),
    .in_year  (in_year),
    .in_month (in_month),
    .in_day   (in_day),
    .step_out (step_q)
  );

  gdsu_facts u_facts (
    .clk       (clk),
    .rst       (rst),
    .step_in   (step_q),
    .facts_out (facts_q)
  );

  gdsu_result u_result (
    .clk           (clk),
    .rst           (rst),
    .facts_in      (facts_q),
    .done          (done),
    .out_year      (out_year),
    .out_month     (out_month),
    .out_day       (out_day),
    .weekday       (weekday),
    .day_of_year   (day_of_year),
    .left_in_month (left_in_month),
    .left_in_year  (left_in_year),
    .leap_flag     (leap_flag),
    .weekend_flag  (weekend_flag),
    .error_flag    (error_flag)
  );

  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##5 done)
    else $error("accepted transaction without result strobe");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (done && error_flag) |-> (out_year == '0 && out_month == '0 && out_day == '0 &&
                              day_of_year == '0 && !leap_flag && !weekend_flag))
    else $error("error result carries nonzero fields");

  a_date_ok: assert property (@(posedge clk) disable iff (rst)
    (done && !error_flag) |-> (out_month != '0 && out_month <= MONTH_DEC &&
                               out_day != '0 && out_year != '0 &&
                               out_year <= YEAR_MAX && weekday <= 3'd6))
    else $error("result date out of range");

  a_year_len: assert property (@(posedge clk) disable iff (rst)
    (done && !error_flag) |->
      (10'(day_of_year) + 10'(left_in_year) == 10'd365 + 10'(leap_flag)))
    else $error("day of year and days left disagree with year length");

  a_weekend: assert property (@(posedge clk) disable iff (rst)
    done |-> (weekend_flag == (weekday == 3'd5 || weekday == 3'd6)))
    else $error("weekend flag does not match weekday");

endmodule

>>> tb/gregorian_date_step_unit_core_tb.sv
`timescale 1ns / 100ps
// gregorian_date_step_unit_core_tb: self-checking testbench for the date step unit
// drives directed and random date commands and checks every result against a
// built-in calendar predictor; depends on gdsu_pkg and gregorian_date_step_unit_core
module gregorian_date_step_unit_core_tb;
  import gdsu_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int ITEMS_PER_PHASE = 325;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [WD_W-1:0]    wday;
    logic [DOY_W-1:0]   doy;
    logic [DAY_W-1:0]   month_left;
    logic [DOY_W-1:0]   year_left;
    logic               leap;
    logic               weekend;
    logic               err;
  } date_facts_t;

  class date_scoreboard;
    localparam int FRIDAY = 5;
    localparam int SATURDAY = 6;
    localparam int PRINT_CAP = 40;

    date_facts_t due_facts[$];
    int          fail_count;
    int          checked;

    static function bit is_leap_year(int y);
      return (y % 400 == 0) || (y % 4 == 0 && y % 100 != 0);
    endfunction

    static function int month_days(int y, int m);
      int n;
      case (m)
        2:           n = is_leap_year(y) ? 29 : 28;
        4, 6, 9, 11: n = 30;
        default:     n = 31;
      endcase
      return n;
    endfunction

    static function date_facts_t step_date(logic [CMD_W-1:0] c, logic [YEAR_W-1:0] yi,
                                           logic [MONTH_W-1:0] mi, logic [DAY_W-1:0] di);
      date_facts_t r;
      int y, m, d, dim, a, yy, mm, wd, doy, k;
      bit leap, bad;
      r = '0;
      y = yi;
      m = mi;
      d = di;
      bad = (y < 1) || (y > YEAR_MAX) || (m < MONTH_JAN) || (m > MONTH_DEC) ||
            (d < 1) || (d > month_days(y, m));
      if (!bad) begin
        case (c)
          CMD_NEXT_DAY: begin
            if (d == month_days(y, m)) begin
              d = 1;
              if (m == MONTH_DEC) begin
                m = MONTH_JAN;
                y++;
              end else begin
                m++;
              end
            end else begin
              d++;
            end
          end
          CMD_PREV_DAY: begin
            if (d == 1) begin
              if (m == MONTH_JAN) begin
                m = MONTH_DEC;
                y--;
                d = 31;
              end else begin
                m--;
                d = month_days(y, m);
              end
            end else begin
              d--;
            end
          end
          CMD_NEXT_MONTH: begin
            if (m == MONTH_DEC) begin
              m = MONTH_JAN;
              y++;
            end else begin
              m++;
            end
          end
          CMD_PREV_MONTH: begin
            if (m == MONTH_JAN) begin
              m = MONTH_DEC;
              y--;
            end else begin
              m--;
            end
          end
          default: ;
        endcase
        bad = (y < 1) || (y > YEAR_MAX);
      end
      if (bad) begin
        r.err = 1'b1;
        return r;
      end
      // month steps clamp the day to the new month
      dim = month_days(y, m);
      if (d > dim) d = dim;
      leap = is_leap_year(y);
      doy = d;
      for (k = 1; k < m; k++) doy += month_days(y, k);
      a = (14 - m) / 12;
      yy = y - a;
      mm = m + 12 * a - 2;
      wd = (d + yy + yy / 4 - yy / 100 + yy / 400 + (31 * mm) / 12) % 7;
      r.year       = YEAR_W'(y);
      r.month      = MONTH_W'(m);
      r.day        = DAY_W'(d);
      r.wday       = WD_W'(wd);
      r.doy        = DOY_W'(doy);
      r.month_left = DAY_W'(dim - d);
      r.year_left  = DOY_W'(365 + leap - doy);
      r.leap       = leap;
      r.weekend    = (wd == FRIDAY) || (wd == SATURDAY);
      return r;
    endfunction

    function int pending();
      return due_facts.size();
    endfunction

    task report_mismatch(string msg);
      fail_count++;
      if (fail_count <= PRINT_CAP) $display("mismatch at transaction %0d: %s", checked, msg);
    endtask

    function void note_request(logic [CMD_W-1:0] c, logic [YEAR_W-1:0] y,
                               logic [MONTH_W-1:0] m, logic [DAY_W-1:0] d);
      due_facts.push_back(step_date(c, y, m, d));
    endfunction

    task check_result(date_facts_t got);
      date_facts_t want;
      if (due_facts.size() == 0) begin
        report_mismatch("result with no transaction outstanding");
      end else begin
        want = due_facts.pop_front();
        if (got.year !== want.year)
          report_mismatch($sformatf("out_year %0d exp %0d", got.year, want.year));
        if (got.month !== want.month)
          report_mismatch($sformatf("out_month %0d exp %0d", got.month, want.month));
        if (got.day !== want.day)
          report_mismatch($sformatf("out_day %0d exp %0d", got.day, want.day));
        if (got.wday !== want.wday)
          report_mismatch($sformatf("weekday %0d exp %0d", got.wday, want.wday));
        if (got.doy !== want.doy)
          report_mismatch($sformatf("day_of_year %0d exp %0d", got.doy, want.doy));
        if (got.month_left !== want.month_left)
          report_mismatch($sformatf("left_in_month %0d exp %0d",
                                    got.month_left, want.month_left));
        if (got.year_left !== want.year_left)
          report_mismatch($sformatf("left_in_year %0d exp %0d",
                                    got.year_left, want.year_left));
        if (got.leap !== want.leap)
          report_mismatch($sformatf("leap_flag %0d exp %0d", got.leap, want.leap));
        if (got.weekend !== want.weekend)
          report_mismatch($sformatf("weekend_flag %0d exp %0d", got.weekend, want.weekend));
        if (got.err !== want.err)
          report_mismatch($sformatf("error_flag %0d exp %0d", got.err, want.err));
      end
      checked++;
    endtask
  endclass

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic [CMD_W-1:0]   cmd;
  logic [YEAR_W-1:0]  in_year;
  logic [MONTH_W-1:0] in_month;
  logic [DAY_W-1:0]   in_day;
  logic               done;
  logic [YEAR_W-1:0]  out_year;
  logic [MONTH_W-1:0] out_month;
  logic [DAY_W-1:0]   out_day;
  logic [WD_W-1:0]    weekday;
  logic [DOY_W-1:0]   day_of_year;
  logic [DAY_W-1:0]   left_in_month;
  logic [DOY_W-1:0]   left_in_year;
  logic               leap_flag;
  logic               weekend_flag;
  logic               error_flag;

  int             quiet_cycles = 0;
  date_scoreboard ledger = new();

  gregorian_date_step_unit_core u_top (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .cmd           (cmd),
    .in_year       (in_year),
    .in_month      (in_month),
    .in_day        (in_day),
    .done          (done),
    .out_year      (out_year),
    .out_month     (out_month),
    .out_day       (out_day),
    .weekday       (weekday),
    .day_of_year   (day_of_year),
    .left_in_month (left_in_month),
    .left_in_year  (left_in_year),
    .leap_flag     (leap_flag),
    .weekend_flag  (weekend_flag),
    .error_flag    (error_flag)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // values read here are the ones present before the edge
  always @(posedge clk) begin
    if (!rst && start && !busy) ledger.note_request(cmd, in_year, in_month, in_day);
    if (done === 1'b1) begin
      ledger.check_result('{year: out_year, month: out_month, day: out_day, wday: weekday,
                            doy: day_of_year, month_left: left_in_month,
                            year_left: left_in_year, leap: leap_flag,
                            weekend: weekend_flag, err: error_flag});
    end
    if ((start && !busy) || done) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("FAIL");
    $finish;
  end

  task automatic send_date(logic [CMD_W-1:0] c, logic [YEAR_W-1:0] y,
                           logic [MONTH_W-1:0] m, logic [DAY_W-1:0] d);
    start    <= 1'b1;
    cmd      <= c;
    in_year  <= y;
    in_month <= m;
    in_day   <= d;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic hold_off(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (ledger.pending() != 0) @(posedge clk);
  endtask

  task automatic send_random_date();
    logic [CMD_W-1:0]   c;
    logic [YEAR_W-1:0]  y;
    logic [MONTH_W-1:0] m;
    logic [DAY_W-1:0]   d;
    int                 len;
    if ($urandom_range(0, 99) < 12) begin
      c = CMD_W'($urandom);
      y = YEAR_W'($urandom);
      m = MONTH_W'($urandom);
      d = DAY_W'($urandom);
    end else begin
      if ($urandom_range(0, 19) == 0)
        c = CMD_W'($urandom_range(CMD_PREV_MONTH + 1, (1 << CMD_W) - 1));
      else
        c = CMD_W'($urandom_range(CMD_QUERY, CMD_PREV_MONTH));
      case ($urandom_range(0, 3))
        0: y = YEAR_W'(100 * $urandom_range(1, 99));
        1: y = $urandom_range(0, 1) ? YEAR_W'($urandom_range(1, 3))
                                    : YEAR_W'($urandom_range(YEAR_MAX - 2, YEAR_MAX));
        default: y = YEAR_W'($urandom_range(1, YEAR_MAX));
      endcase
      m = MONTH_W'($urandom_range(MONTH_JAN, MONTH_DEC));
      len = date_scoreboard::month_days(y, m);
      case ($urandom_range(0, 3))
        0: d = 1;
        1: d = DAY_W'(len);
        default: d = DAY_W'($urandom_range(1, len));
      endcase
    end
    send_date(c, y, m, d);
  endtask

  initial begin
    int idle_pct[4];
    int ph;
    int k;
    int c;
    idle_pct = '{0, 54, 0, 29};
    rst      <= 1'b1;
    start    <= 1'b0;
    cmd      <= CMD_QUERY;
    in_year  <= '0;
    in_month <= '0;
    in_day   <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // leap rules and invalid dates
    send_date(CMD_QUERY, 2024, MONTH_FEB, 29);
    send_date(CMD_QUERY, 2023, MONTH_FEB, 29);
    send_date(CMD_QUERY, 1900, MONTH_FEB, 29);
    send_date(CMD_QUERY, 2000, MONTH_FEB, 29);
    send_date(CMD_QUERY, 0, MONTH_JAN, 1);
    send_date(CMD_QUERY, '1, '1, '1);
    send_date(CMD_QUERY, YEAR_MAX + 1, MONTH_JAN, 1);
    send_date(CMD_QUERY, 2020, 0, 5);
    send_date(CMD_QUERY, 2020, MONTH_DEC + 1, 1);
    send_date(CMD_QUERY, 2020, 4, 31);
    send_date(CMD_QUERY, 2020, 6, 0);
    // day steps across month, year and range limits
    send_date(CMD_NEXT_DAY, YEAR_MAX, MONTH_DEC, 31);
    send_date(CMD_NEXT_DAY, 2023, MONTH_DEC, 31);
    send_date(CMD_NEXT_DAY, 2024, MONTH_FEB, 28);
    send_date(CMD_NEXT_DAY, 2023, MONTH_FEB, 28);
    send_date(CMD_PREV_DAY, 1, MONTH_JAN, 1);
    send_date(CMD_PREV_DAY, 2024, 3, 1);
    send_date(CMD_PREV_DAY, 2024, MONTH_JAN, 1);
    // month steps with wrap and clamp
    send_date(CMD_NEXT_MONTH, 2024, MONTH_JAN, 31);
    send_date(CMD_NEXT_MONTH, 2023, MONTH_DEC, 15);
    send_date(CMD_NEXT_MONTH, YEAR_MAX, MONTH_DEC, 1);
    send_date(CMD_PREV_MONTH, 2023, 3, 31);
    send_date(CMD_PREV_MONTH, 1, MONTH_JAN, 20);
    send_date(CMD_PREV_MONTH, 2024, MONTH_JAN, 31);
    // unused command codes behave as a query
    for (c = CMD_PREV_MONTH + 1; c < (1 << CMD_W); c++)
      send_date(CMD_W'(c), YEAR_MAX, MONTH_DEC, 31);

    for (ph = 0; ph < 4; ph++) begin
      for (k = 0; k < ITEMS_PER_PHASE; k++) begin
        send_random_date();
        if (idle_pct[ph] != 0 && $urandom_range(0, 99) < idle_pct[ph])
          hold_off($urandom_range(1, 6));
      end
      if (ph == 1) drain_results();
    end

    drain_results();
    repeat (10) @(posedge clk);
    if (ledger.fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
